@@ sv/ius_pkg.sv @@
// ----------------------------------------------------------------------------
// ius_pkg
// Shared constants and types of the integer pixel replication upscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package ius_pkg;

	// line store geometry
	localparam int MAX_WIDTH = 1024;
	localparam int ADDR_W    = $clog2(MAX_WIDTH);
	localparam int PIX_W     = 24;

	// configuration limits
	localparam logic [6:0] SCALE_MAX = 7'd100;

	// result queue geometry
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// command codes
	localparam logic CMD_PIXEL  = 1'b0;
	localparam logic CMD_REPLAY = 1'b1;

	// status codes
	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	// configuration register indexes
	localparam logic CFG_SCALE = 1'b0;
	localparam logic CFG_WIDTH = 1'b1;

	// one result word
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [6:0] repeat_count;
		logic [1:0] pad_bytes;
		logic       row_end;
		logic       status;
	} res_t;

	// line store access from the front part
	typedef struct packed {
		logic              wr_en;
		logic              rd_en;
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  wdata;
	} mem_req_t;

endpackage

`default_nettype wire

@@ sv/ius_ram.sv @@
// ----------------------------------------------------------------------------
// ius_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ius_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[addr] <= wdata;
		end
		if (rd_en) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

`default_nettype wire

@@ sv/ius_front.sv @@
// ----------------------------------------------------------------------------
// ius_front
// Accepts and classifies input words, keeps the row and replay positions,
// drives the line store and hands finished results to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ius_front (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// configuration
	input  wire logic                     cfg_valid,
	input  wire logic                     cfg_index,
	input  wire logic [10:0]              cfg_data,
	// input channel
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic                     cmd,
	input  wire logic [7:0]               blue_in,
	input  wire logic [7:0]               green_in,
	input  wire logic [7:0]               red_in,
	// line store
	output ius_pkg::mem_req_t             mem_req,
	input  wire logic [ius_pkg::PIX_W-1:0] mem_rdata,
	// result queue
	input  wire logic [ius_pkg::QCNT_W-1:0] q_count,
	output logic                          push,
	output ius_pkg::res_t                 push_res
);

	logic [6:0]                   scale_q;
	logic [10:0]                  row_width_q;
	logic [ius_pkg::ADDR_W-1:0]   column_q;
	logic [6:0]                   replays_left_q;
	logic [ius_pkg::ADDR_W-1:0]   replay_column_q;

	logic [6:0]                   eff_scale;
	logic [10:0]                  eff_width;
	logic [ius_pkg::ADDR_W-1:0]   last;
	logic [1:0]                   prod;
	logic [1:0]                   pad;
	logic [ius_pkg::QCNT_W:0]     occupancy;
	logic                         accept;
	logic                         is_pixel;
	logic                         is_replay;
	logic                         pix_end;
	logic                         rep_end;

	// stage 1 holds the classified word while the line store read completes
	logic                         valid_s1;
	logic                         use_ram_s1;
	ius_pkg::res_t                res_s1;

	// effective configuration
	always_comb begin
		if (scale_q == 7'd0) begin
			eff_scale = 7'd1;
		end else if (scale_q > ius_pkg::SCALE_MAX) begin
			eff_scale = ius_pkg::SCALE_MAX;
		end else begin
			eff_scale = scale_q;
		end
		if (row_width_q == 11'd0) begin
			eff_width = 11'd1;
		end else if (row_width_q > 11'(ius_pkg::MAX_WIDTH)) begin
			eff_width = 11'(ius_pkg::MAX_WIDTH);
		end else begin
			eff_width = row_width_q;
		end
		last = ius_pkg::ADDR_W'(eff_width - 11'd1);
		// output row padding depends only on the low two bits of the byte count
		prod = eff_width[1:0] * eff_scale[1:0] * 2'd3;
		pad  = 2'd0 - prod;
	end

	// flow control: room for the word in flight plus a new one
	assign occupancy = {1'b0, q_count} + {{ius_pkg::QCNT_W{1'b0}}, valid_s1};
	assign in_stall  = (occupancy >= (ius_pkg::QCNT_W + 1)'(ius_pkg::QDEPTH));
	assign accept    = in_valid && !in_stall;

	// classification
	assign is_pixel  = (cmd == ius_pkg::CMD_PIXEL) && (replays_left_q == 7'd0);
	assign is_replay = (cmd == ius_pkg::CMD_REPLAY) && (replays_left_q != 7'd0);
	assign pix_end   = (column_q >= last);
	assign rep_end   = (replay_column_q >= last);

	// line store access
	always_comb begin
		mem_req.wr_en = accept && is_pixel;
		mem_req.rd_en = accept && is_replay;
		mem_req.addr  = is_pixel ? column_q : replay_column_q;
		mem_req.wdata = {red_in, green_in, blue_in};
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q     <= 7'd1;
			row_width_q <= 11'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ius_pkg::CFG_SCALE: scale_q     <= cfg_data[6:0];
				ius_pkg::CFG_WIDTH: row_width_q <= cfg_data;
				default:            scale_q     <= scale_q;
			endcase
		end
	end

	// row and replay positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q        <= '0;
			replays_left_q  <= 7'd0;
			replay_column_q <= '0;
		end else if (accept) begin
			if (is_pixel) begin
				if (pix_end) begin
					column_q        <= '0;
					replays_left_q  <= eff_scale - 7'd1;
					replay_column_q <= '0;
				end else begin
					column_q <= column_q + 1'b1;
				end
			end else if (is_replay) begin
				if (rep_end) begin
					replay_column_q <= '0;
					replays_left_q  <= replays_left_q - 7'd1;
				end else begin
					replay_column_q <= replay_column_q + 1'b1;
				end
			end
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			use_ram_s1 <= is_replay;
			if (is_pixel || is_replay) begin
				res_s1.blue         <= blue_in;
				res_s1.green        <= green_in;
				res_s1.red          <= red_in;
				res_s1.repeat_count <= eff_scale;
				res_s1.row_end      <= is_pixel ? pix_end : rep_end;
				res_s1.pad_bytes    <= (is_pixel ? pix_end : rep_end) ? pad : 2'd0;
				res_s1.status       <= ius_pkg::STATUS_OK;
			end else begin
				res_s1.blue         <= 8'd0;
				res_s1.green        <= 8'd0;
				res_s1.red          <= 8'd0;
				res_s1.repeat_count <= 7'd0;
				res_s1.row_end      <= 1'b0;
				res_s1.pad_bytes    <= 2'd0;
				res_s1.status       <= ius_pkg::STATUS_REJECT;
			end
		end
	end

	// merge replayed pixel from the line store
	always_comb begin
		push     = valid_s1;
		push_res = res_s1;
		if (use_ram_s1) begin
			push_res.blue  = mem_rdata[7:0];
			push_res.green = mem_rdata[15:8];
			push_res.red   = mem_rdata[23:16];
		end
	end

endmodule

`default_nettype wire

@@ sv/ius_queue.sv @@
// ----------------------------------------------------------------------------
// ius_queue
// Result queue and output side: holds finished words and drains them to the
// output channel independently of the front part.
// ----------------------------------------------------------------------------
`default_nettype none

module ius_queue (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	input  wire ius_pkg::res_t               push_res,
	output logic [ius_pkg::QCNT_W-1:0]       count,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output ius_pkg::res_t                    head
);

	ius_pkg::res_t               entries_q [ius_pkg::QDEPTH];
	logic [ius_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [ius_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [ius_pkg::QCNT_W-1:0]  count_q;
	logic                        pop;

	assign count     = count_q;
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;
	assign head      = entries_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_res;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ sv/integer_pixel_replication_upscaler_core.sv @@
// ----------------------------------------------------------------------------
// integer_pixel_replication_upscaler_core
// Upscales a 24-bit pixel stream by whole-number pixel replication.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: write scale (index 0) and row_width (index 1) through
//   cfg_valid/cfg_index/cfg_data while the block is idle; cfg_ready is
//   always high.
//   Input: one word per cycle on in_valid/in_stall while in_stall is low;
//   cmd 0 carries a pixel, cmd 1 a replay step. After each row, scale-1
//   repeated rows are driven by replay steps, one per pixel. Words in the
//   wrong phase are rejected with status 1.
//   Output: one result word per input word on out_valid/out_stall, in order.
//   Each accepted word is registered in stage 1 while the line store read
//   completes, then written into the result queue for the output.
//   Throughput is one word per cycle while in_stall is low, set by the
//   single line store port.
//   A stalled receiver fills the four-entry result queue; in_stall rises
//   once queued plus in-flight words reach its depth.
//   Reset clears positions and pending replays, sets scale and row_width to
//   one and empties the queue; the line store keeps its contents.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_pixel_replication_upscaler_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [10:0] cfg_data,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        cmd,
	input  wire logic [7:0]  blue_in,
	input  wire logic [7:0]  green_in,
	input  wire logic [7:0]  red_in,
	// output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       blue_out,
	output logic [7:0]       green_out,
	output logic [7:0]       red_out,
	output logic [6:0]       repeat_count,
	output logic [1:0]       pad_bytes,
	output logic             row_end,
	output logic             status
);

	ius_pkg::mem_req_t            mem_req;
	logic [ius_pkg::PIX_W-1:0]    mem_rdata;
	logic [ius_pkg::QCNT_W-1:0]   q_count;
	logic                         push;
	ius_pkg::res_t                push_res;
	ius_pkg::res_t                head;

	assign cfg_ready = 1'b1;

	// front part: classify and track positions
	ius_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.blue_in   (blue_in),
		.green_in  (green_in),
		.red_in    (red_in),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.q_count   (q_count),
		.push      (push),
		.push_res  (push_res)
	);

	// line store
	ius_ram #(
		.WIDTH (ius_pkg::PIX_W),
		.DEPTH (ius_pkg::MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.wr_en (mem_req.wr_en),
		.rd_en (mem_req.rd_en),
		.addr  (mem_req.addr),
		.wdata (mem_req.wdata),
		.rdata (mem_rdata)
	);

	// back part: result queue and output channel
	ius_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_res  (push_res),
		.count     (q_count),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	// output fields
	assign blue_out     = head.blue;
	assign green_out    = head.green;
	assign red_out      = head.red;
	assign repeat_count = head.repeat_count;
	assign pad_bytes    = head.pad_bytes;
	assign row_end      = head.row_end;
	assign status       = head.status;

endmodule

`default_nettype wire

@@ sim/integer_pixel_replication_upscaler_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_pixel_replication_upscaler_core_tb
// Drives pixel and replay words into the upscaler, with random sender gaps
// and receiver stalls, and checks every run word against its own predictor
// of the line store, row positions and owed replay rows. The configuration
// registers are changed between bursts of traffic, once the block is idle.
// ----------------------------------------------------------------------------

module integer_pixel_replication_upscaler_core_tb;

	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned WORD_TARGET = 1150;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned DRAIN_CYCLES = 8;

	// one input word as the sender holds it
	typedef struct packed {
		logic                      cmd;
		logic [ius_pkg::PIX_W-1:0] pix;
	} pix_word_t;

	// row and replay positions of the upscaler
	typedef struct packed {
		logic [ius_pkg::ADDR_W-1:0] column;
		logic [6:0]                 replays_left;
		logic [ius_pkg::ADDR_W-1:0] replay_column;
	} row_pos_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = ius_pkg::CFG_SCALE;
	logic [10:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        cmd = ius_pkg::CMD_PIXEL;
	logic [7:0]  blue_in = '0;
	logic [7:0]  green_in = '0;
	logic [7:0]  red_in = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  blue_out;
	logic [7:0]  green_out;
	logic [7:0]  red_out;
	logic [6:0]  repeat_count;
	logic [1:0]  pad_bytes;
	logic        row_end;
	logic        status;

	// predictor state
	logic [6:0]                cfg_scale = 7'd1;
	logic [10:0]               cfg_width = 11'd1;
	logic [ius_pkg::PIX_W-1:0] line_mem [ius_pkg::MAX_WIDTH];
	row_pos_t                  row_pos = '0;

	pix_word_t       pending_words [$];
	ius_pkg::res_t   runs_due [$];
	int unsigned     mismatches = 0;
	int unsigned     runs_seen = 0;
	int unsigned     cycle_count = 0;
	logic            word_taken = 1'b0;
	logic            tx_steady = 1'b0;
	logic            rx_steady = 1'b0;
	int unsigned     hold_asks = 0;
	int unsigned     holds_served = 0;

	integer_pixel_replication_upscaler_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.blue_in      (blue_in),
		.green_in     (green_in),
		.red_in       (red_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.blue_out     (blue_out),
		.green_out    (green_out),
		.red_out      (red_out),
		.repeat_count (repeat_count),
		.pad_bytes    (pad_bytes),
		.row_end      (row_end),
		.status       (status)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// scale as the block applies it
	function automatic int unsigned eff_scale();
		if (cfg_scale == 7'd0) return 1;
		if (cfg_scale > ius_pkg::SCALE_MAX) return ius_pkg::SCALE_MAX;
		return cfg_scale;
	endfunction

	// row width as the block applies it
	function automatic int unsigned eff_width();
		if (cfg_width == 11'd0) return 1;
		if (cfg_width > ius_pkg::MAX_WIDTH) return ius_pkg::MAX_WIDTH;
		return cfg_width;
	endfunction

	// moves the positions on by one word; 0 when the word is rejected
	function automatic bit step_pos(inout row_pos_t p, input logic c,
		input int unsigned wl, input int unsigned sc, output bit done);
		done = 1'b0;
		if (c == ius_pkg::CMD_PIXEL) begin
			if (p.replays_left != 0) return 1'b0;
			done = p.column >= wl - 1;
			if (done) begin
				p.column = '0;
				p.replays_left = 7'(sc - 1);
				p.replay_column = '0;
			end else begin
				p.column = p.column + 1'b1;
			end
		end else begin
			if (p.replays_left == 0) return 1'b0;
			done = p.replay_column >= wl - 1;
			if (done) begin
				p.replay_column = '0;
				p.replays_left = p.replays_left - 1'b1;
			end else begin
				p.replay_column = p.replay_column + 1'b1;
			end
		end
		return 1'b1;
	endfunction

	// expected run word for one accepted input word
	function automatic ius_pkg::res_t predict_run(input logic c,
		input logic [ius_pkg::PIX_W-1:0] pix);
		ius_pkg::res_t              r;
		bit                         took;
		bit                         done;
		logic [ius_pkg::ADDR_W-1:0] col;
		logic [ius_pkg::ADDR_W-1:0] rcol;
		logic [ius_pkg::PIX_W-1:0]  run_pix;
		int unsigned                bytes;
		r = '0;
		col = row_pos.column;
		rcol = row_pos.replay_column;
		took = step_pos(row_pos, c, eff_width(), eff_scale(), done);
		if (!took) begin
			r.status = ius_pkg::STATUS_REJECT;
			return r;
		end
		if (c == ius_pkg::CMD_PIXEL) begin
			line_mem[col] = pix;
			run_pix = pix;
		end else begin
			run_pix = line_mem[rcol];
		end
		r.blue = run_pix[7:0];
		r.green = run_pix[15:8];
		r.red = run_pix[23:16];
		r.repeat_count = 7'(eff_scale());
		if (done) begin
			bytes = 3 * eff_width() * eff_scale();
			r.pad_bytes = 2'((4 - bytes % 4) % 4);
			r.row_end = 1'b1;
		end
		r.status = ius_pkg::STATUS_OK;
		return r;
	endfunction

	// short gaps mostly, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic int unsigned pick_stall();
		if ($urandom_range(4) != 0) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= 100)
			$display("mismatch at run %0d: %s", runs_seen, msg);
	endtask

	task automatic cmp_field(input string name, input int got, input int want);
		if (got != want) report($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	task automatic check_run(input ius_pkg::res_t got);
		ius_pkg::res_t want;
		if (runs_due.size() == 0) begin
			report($sformatf("run word %h with nothing due", got));
			return;
		end
		want = runs_due.pop_front();
		cmp_field("blue", got.blue, want.blue);
		cmp_field("green", got.green, want.green);
		cmp_field("red", got.red, want.red);
		cmp_field("repeat_count", got.repeat_count, want.repeat_count);
		cmp_field("pad_bytes", got.pad_bytes, want.pad_bytes);
		cmp_field("row_end", got.row_end, want.row_end);
		cmp_field("status", got.status, want.status);
	endtask

	// sample accepted words on both channels, watch the cycle limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL integer_pixel_replication_upscaler_core");
			$finish;
		end else begin
			word_taken = in_valid && !in_stall;
			if (word_taken)
				runs_due.push_back(predict_run(cmd, {red_in, green_in, blue_in}));
			if (out_valid && !out_stall) begin
				runs_seen++;
				check_run({blue_out, green_out, red_out, repeat_count, pad_bytes,
					row_end, status});
			end
		end
	end

	// sender: next word from the pending queue, with random gaps
	always @(negedge clk) begin : drive_words
		pix_word_t   nxt;
		int unsigned gap_left;
		if (!in_valid || word_taken) begin
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				nxt = pending_words.pop_front();
				in_valid <= 1'b1;
				cmd <= nxt.cmd;
				{red_in, green_in, blue_in} <= nxt.pix;
				gap_left = tx_steady ? 0 : pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus a long hold when one is asked for
	always @(negedge clk) begin : drive_stall
		int unsigned hold_left;
		int unsigned stall_left;
		if (holds_served != hold_asks) begin
			holds_served++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (!rx_steady && $urandom_range(3) == 0) stall_left = pick_stall();
		end
	end

	task automatic put_word(input logic c, input logic [ius_pkg::PIX_W-1:0] pix);
		pending_words.push_back('{cmd: c, pix: pix});
	endtask

	// wait until every queued word has gone in and every run has come out;
	// checked at the rising edge, where the sender's outputs are settled
	task automatic settle();
		do @(posedge clk);
		while (pending_words.size() != 0 || in_valid || runs_due.size() != 0);
	endtask

	task automatic write_reg(input logic idx, input logic [10:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == ius_pkg::CFG_SCALE) cfg_scale = val[6:0];
		else cfg_width = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly well-formed rows and replays, some words in the wrong phase;
	// adds the number of words queued to sent
	task automatic random_burst(input int unsigned n, inout int unsigned sent);
		row_pos_t    plan;
		logic        c;
		bit          done;
		plan = row_pos;
		for (int unsigned i = 0; i < n; i++) begin
			c = (plan.replays_left != 0) ? ius_pkg::CMD_REPLAY : ius_pkg::CMD_PIXEL;
			if ($urandom_range(9) == 0) c = ~c;
			void'(step_pos(plan, c, eff_width(), eff_scale(), done));
			put_word(c, 24'($urandom));
			sent++;
		end
	endtask

	// stimulus
	initial begin
		int unsigned sent;
		int unsigned burst;
		int unsigned r;
		logic [10:0] val;
		sent = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: replay with nothing owed, then one-pixel rows
		put_word(ius_pkg::CMD_REPLAY, 24'h123456);
		put_word(ius_pkg::CMD_PIXEL, 24'h000000);
		put_word(ius_pkg::CMD_PIXEL, 24'hFFFFFF);
		settle();
		// scale field of zero, upper data bits set, acts as one
		write_reg(ius_pkg::CFG_SCALE, 11'h780);
		put_word(ius_pkg::CMD_PIXEL, 24'hA5A5A5);
		settle();
		// two-pixel rows tripled, with a pixel and a replay out of phase
		write_reg(ius_pkg::CFG_SCALE, 11'd3);
		write_reg(ius_pkg::CFG_WIDTH, 11'd2);
		put_word(ius_pkg::CMD_PIXEL, 24'h0000FF);
		put_word(ius_pkg::CMD_PIXEL, 24'hFF0000);
		put_word(ius_pkg::CMD_PIXEL, 24'h00FF00);
		repeat (4) put_word(ius_pkg::CMD_REPLAY, 24'h5A5A5A);
		put_word(ius_pkg::CMD_REPLAY, 24'h000000);
		settle();
		// width zero acts as one; scale lowered while replays are owed
		write_reg(ius_pkg::CFG_SCALE, 11'd5);
		write_reg(ius_pkg::CFG_WIDTH, 11'd0);
		put_word(ius_pkg::CMD_PIXEL, 24'h3C3C3C);
		repeat (2) put_word(ius_pkg::CMD_REPLAY, 24'hFFFFFF);
		settle();
		write_reg(ius_pkg::CFG_SCALE, 11'd1);
		repeat (3) put_word(ius_pkg::CMD_REPLAY, 24'h000000);
		settle();
		// width above the line store, then lowered in mid-row
		write_reg(ius_pkg::CFG_WIDTH, 11'h7FF);
		write_reg(ius_pkg::CFG_SCALE, 11'd2);
		put_word(ius_pkg::CMD_PIXEL, 24'h112233);
		put_word(ius_pkg::CMD_PIXEL, 24'h445566);
		put_word(ius_pkg::CMD_PIXEL, 24'h778899);
		settle();
		write_reg(ius_pkg::CFG_WIDTH, 11'd2);
		put_word(ius_pkg::CMD_PIXEL, 24'hAABBCC);
		repeat (2) put_word(ius_pkg::CMD_REPLAY, 24'h0F0F0F);
		settle();

		// top scale with all data bits set
		write_reg(ius_pkg::CFG_WIDTH, 11'd3);
		write_reg(ius_pkg::CFG_SCALE, 11'h7FF);
		random_burst(60, sent);

		for (int unsigned phase = 0; sent < WORD_TARGET; phase++) begin
			settle();
			tx_steady = $urandom_range(4) == 0;
			rx_steady = $urandom_range(4) == 0;
			// new row width; never widened while replay rows are owed
			if (eff_width() > 64 || $urandom_range(1) == 0) begin
				r = $urandom_range(99);
				if (eff_width() > 64) val = 11'($urandom_range(1, 4));
				else if (row_pos.replays_left != 0)
					val = 11'($urandom_range(1, eff_width()));
				else if (r < 70) val = 11'($urandom_range(1, 8));
				else if (r < 85) val = 11'($urandom_range(9, 40));
				else if (r < 92) val = 11'd0;
				else val = 11'($urandom_range(ius_pkg::MAX_WIDTH, 2047));
				write_reg(ius_pkg::CFG_WIDTH, val);
			end
			// new scale; the largest only on narrow rows
			if ($urandom_range(1) == 0) begin
				r = $urandom_range(99);
				val[10:7] = 4'($urandom);
				if (r < 8) val[6:0] = 7'd0;
				else if (r < 14 && eff_width() <= 4) val[6:0] = 7'($urandom_range(100, 127));
				else if (r < 70) val[6:0] = 7'($urandom_range(1, 4));
				else val[6:0] = 7'($urandom_range(5, 12));
				write_reg(ius_pkg::CFG_SCALE, val);
			end
			burst = $urandom_range(10, 80);
			// receiver holds off while the sender keeps going
			if (phase == 3 || phase == 12) begin
				tx_steady = 1'b1;
				burst = 60;
				hold_asks++;
			end
			random_burst(burst, sent);
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS integer_pixel_replication_upscaler_core");
		else
			$display("FAIL integer_pixel_replication_upscaler_core");
		$finish;
	end

endmodule
